// ===== rtl/zsw_pkg.sv =====
// ----------------------------------------------------------------------------
// zsw_pkg : shared types and constants for the z-spline weighted grid sum
// Fixed-point widths, stream packing, kernel coefficient tables and the
// request that carries one contribution into the accumulator.
// ----------------------------------------------------------------------------
package zsw_pkg;

  // build-time configuration
  localparam int DIMS       = 2;    // 2 or 3
  localparam int INDEX_BITS = 10;   // 4 to 14

  // field widths
  localparam int POS_W    = 24;
  localparam int POS_FRAC = 14;
  localparam int CELL_W   = 10;
  localparam int SMP_W    = 32;
  localparam int OUT_W    = 48;
  localparam int SUM_W    = 56;

  // stream packing
  localparam int CELL_LSB  = 3 * POS_W;
  localparam int SMP_LSB   = CELL_LSB + 3 * CELL_W;
  localparam int IN_DATA_W = ((SMP_LSB + SMP_W + 7) / 8) * 8;

  localparam int DIM_W = (DIMS > 2) ? 2 : 1;

  localparam logic [CELL_W-1:0] CELL_MASK =
    (INDEX_BITS >= CELL_W) ? {CELL_W{1'b1}} : CELL_W'((1 << INDEX_BITS) - 1);

  // datapath widths
  localparam int OFF_W  = POS_W + 2;   // signed offset in Q.14
  localparam int MAG_W  = 16;          // |offset| below three cells
  localparam int FRAC_W = 30;          // Q2.30 kernel and weight
  localparam int COEF_W = 11;
  localparam int ACC_W  = 46;          // horner accumulator, Q.30
  localparam int KERN_W = 33;          // kernel and weight, Q2.30
  localparam int MA_W   = 48;          // shared multiplier, wide operand
  localparam int MB_W   = 17;          // shared multiplier, narrow operand
  localparam int PROD_W = MA_W + MB_W;
  localparam int PSUM_W = 68;          // two-pass product
  localparam int CON_W  = 40;          // contribution, Q24.16

  localparam int HALF_CELL = 1 << (POS_FRAC - 1);
  localparam int ONE_Q30   = 1 << FRAC_W;
  localparam int FAR_CELLS = 3;

  // horner step rounds by 2^14 since t = |offset| << 16
  localparam int H_SH   = FRAC_W - (FRAC_W - POS_FRAC - 2) - 2;
  localparam int RND_H  = 1 << (H_SH - 1);
  localparam int RND_30 = 1 << (FRAC_W - 1);

  // division by 24: divide (|v| + 12) by 8, then by 3 through a reciprocal
  localparam int DIV_BIAS  = 12;
  localparam int DIV_SH    = 3;
  localparam int RECIP3_SH = 33;
  localparam logic [MA_W-1:0] RECIP3 = MA_W'(64'd2863311531);

  typedef enum logic [1:0] {
    ORD_HAT     = 2'd0,
    ORD_CUBIC   = 2'd1,
    ORD_QUINTIC = 2'd2,
    ORD_NONE    = 2'd3
  } order_t;

  typedef enum logic [1:0] {
    MK_WGT = 2'd0,
    MK_CON = 2'd1,
    MK_DIV = 2'd2
  } mkind_t;

  typedef struct packed {
    logic                     valid;
    logic                     last;
    logic signed [CON_W-1:0]  contrib;
  } acc_req_t;

  // segment polynomials scaled by 2 (cubic) and 24 (quintic), lowest power first
  localparam logic signed [COEF_W-1:0] CUB_C [2][4] = '{
    '{ 11'sd2,  11'sd0, -11'sd5,  11'sd3},
    '{ 11'sd4, -11'sd8,  11'sd5, -11'sd1}
  };

  localparam logic signed [COEF_W-1:0] QUIN_C [3][6] = '{
    '{ 11'sd24,    11'sd0,  -11'sd30,  -11'sd70,  11'sd126,  -11'sd50},
    '{-11'sd96,  11'sd450, -11'sd735,  11'sd545, -11'sd189,   11'sd25},
    '{11'sd432, -11'sd918,  11'sd765, -11'sd313,   11'sd63,   -11'sd5}
  };

  function automatic logic signed [COEF_W-1:0] zsw_coef(
    input logic       quin,
    input logic [1:0] seg,
    input logic [2:0] idx
  );
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (quin) begin
      if (seg != 2'd3 && idx <= 3'd5) begin
        c = QUIN_C[seg][idx];
      end
    end else if (seg[1] == 1'b0 && idx[2] == 1'b0) begin
      c = CUB_C[seg[0]][idx[1:0]];
    end
    return c;
  endfunction

endpackage

// ===== rtl/zsw_mul.sv =====
// ----------------------------------------------------------------------------
// zsw_mul : shared signed multiplier
// 48 by 17 bit signed product with a registered output, one result a cycle.
// ----------------------------------------------------------------------------
module zsw_mul import zsw_pkg::*; (
  input  logic                     clk,
  input  logic signed [MA_W-1:0]   a,
  input  logic signed [MB_W-1:0]   b,
  output logic signed [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== rtl/zsw_acc.sv =====
// ----------------------------------------------------------------------------
// zsw_acc : running sum and result register
// Saturating 56-bit accumulation, 48-bit saturated result on the last cell.
// ----------------------------------------------------------------------------
module zsw_acc import zsw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  acc_req_t         req,
  output logic             req_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_data
);

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  logic [SUM_W-1:0] running_sum;
  logic [SUM_W:0]   sum_ext;
  logic [SUM_W-1:0] sum_sat;
  logic [OUT_W-1:0] out_sat;
  logic             ovf_sum;
  logic             ovf_out;
  logic             take;

  always_comb begin
    sum_ext = {running_sum[SUM_W-1], running_sum}
            + {{(SUM_W+1-CON_W){req.contrib[CON_W-1]}}, req.contrib};
    ovf_sum = sum_ext[SUM_W] != sum_ext[SUM_W-1];
    sum_sat = ovf_sum ? (sum_ext[SUM_W] ? SUM_MIN : SUM_MAX) : sum_ext[SUM_W-1:0];
    // clamping twice equals clamping once to the narrower range
    ovf_out = !((&sum_ext[SUM_W:OUT_W-1]) || !(|sum_ext[SUM_W:OUT_W-1]));
    out_sat = ovf_out ? (sum_ext[SUM_W] ? OUT_MIN : OUT_MAX) : sum_ext[OUT_W-1:0];
  end

  assign req_ready = !req.last || !out_valid || out_ready;
  assign take      = req.valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (req.last) begin
          running_sum <= '0;
          out_valid   <= 1'b1;
        end else begin
          running_sum <= sum_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && req.last) begin
      out_data <= out_sat;
    end
  end

endmodule

// ===== rtl/zsw_seq.sv =====
// ----------------------------------------------------------------------------
// zsw_seq : per-cell sequencer and datapath
// Offsets, kernel evaluation by horner steps, weight product and weighted
// sample, with every product through the shared multiplier.
// ----------------------------------------------------------------------------
module zsw_seq import zsw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [IN_DATA_W-1:0]     in_data,
  input  logic                     in_last,
  input  order_t                   kernel_order,
  output logic signed [MA_W-1:0]   mul_a,
  output logic signed [MB_W-1:0]   mul_b,
  input  logic signed [PROD_W-1:0] mul_p,
  output acc_req_t                 acc_req,
  input  logic                     acc_ready
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_OFF  = 12'b0000_0000_0010,
    S_HMUL = 12'b0000_0000_0100,
    S_HADD = 12'b0000_0000_1000,
    S_KFIN = 12'b0000_0001_0000,
    S_WGT  = 12'b0000_0010_0000,
    S_NEXT = 12'b0000_0100_0000,
    S_PHI  = 12'b0000_1000_0000,
    S_PLO  = 12'b0001_0000_0000,
    S_PSUM = 12'b0010_0000_0000,
    S_PFIN = 12'b0100_0000_0000,
    S_ACC  = 12'b1000_0000_0000
  } state_t;

  localparam logic [OFF_W-2:0] FAR_LIM = (OFF_W-1)'(FAR_CELLS << POS_FRAC);

  state_t state, state_next;

  logic [POS_W-1:0]         pos  [DIMS];
  logic [CELL_W-1:0]        cidx [DIMS];
  logic signed [SMP_W-1:0]  sample;
  logic                     last;
  logic [DIM_W-1:0]         dim;
  logic [2:0]               step;
  logic signed [ACC_W-1:0]  acc;
  logic [MAG_W-1:0]         mag;
  logic [1:0]               seg;
  logic signed [KERN_W-1:0] kern;
  logic signed [KERN_W-1:0] weight;
  logic signed [MA_W-1:0]   ma;
  logic signed [KERN_W-1:0] mb;
  mkind_t                   kind;
  logic                     kneg;
  logic signed [PSUM_W-1:0] psum;
  logic signed [CON_W-1:0]  contrib;

  // combinational terms
  logic [CELL_W-1:0]        cell_use;
  logic signed [OFF_W-1:0]  off;
  logic signed [OFF_W-1:0]  off_neg;
  logic [OFF_W-2:0]         off_abs;
  logic [MAG_W-1:0]         mag_c;
  logic [1:0]               seg_c;
  logic                     zero_k;
  logic                     quin;
  logic [2:0]               deg;
  logic signed [KERN_W-1:0] hat_k;
  logic signed [ACC_W-1:0]  start_c;
  logic signed [PROD_W-1:0] p_adj;
  logic signed [PROD_W-1:0] p_shr;
  logic signed [ACC_W-1:0]  acc_new;
  logic signed [ACC_W-1:0]  acc_r1;
  logic signed [ACC_W-1:0]  acc_half;
  logic signed [ACC_W-1:0]  acc_n;
  logic signed [PSUM_W-1:0] mul_p_ext;
  logic signed [PSUM_W-1:0] ps_adj;
  logic signed [PSUM_W-1:0] ps_shr;
  logic signed [PSUM_W-1:0] ps_q;
  logic signed [KERN_W-1:0] q_t;
  logic                     last_dim;

  function automatic logic signed [ACC_W-1:0] coef_q30(input logic signed [COEF_W-1:0] c);
    return {{(ACC_W-COEF_W-FRAC_W){c[COEF_W-1]}}, c, {FRAC_W{1'b0}}};
  endfunction

  always_comb begin
    cell_use = cidx[dim] & CELL_MASK;
    off      = $signed({2'b00, pos[dim]})
             - $signed({2'b00, cell_use, {POS_FRAC{1'b0}}})
             - $signed(OFF_W'(HALF_CELL));
    off_neg  = -off;
    off_abs  = off[OFF_W-1] ? off_neg[OFF_W-2:0] : off[OFF_W-2:0];
    mag_c    = off_abs[MAG_W-1:0];
    seg_c    = mag_c[MAG_W-1:POS_FRAC];
    quin     = kernel_order == ORD_QUINTIC;
    deg      = quin ? 3'd5 : 3'd3;
    zero_k   = (off_abs >= FAR_LIM) || (kernel_order == ORD_NONE)
            || (kernel_order == ORD_CUBIC && seg_c == 2'd2)
            || (kernel_order == ORD_HAT && seg_c != 2'd0);
    hat_k    = KERN_W'(ONE_Q30) - {1'b0, mag_c, {(FRAC_W-POS_FRAC){1'b0}}};
    start_c  = coef_q30(zsw_coef(quin, seg_c, deg));

    // horner step: round(acc * t / 2^30) with t = mag << 16, ties away from zero
    p_adj    = mul_p + (mul_p[PROD_W-1] ? PROD_W'(RND_H - 1) : PROD_W'(RND_H));
    p_shr    = p_adj >>> H_SH;
    acc_new  = p_shr[ACC_W-1:0] + coef_q30(zsw_coef(quin, seg, step));

    // cubic: halve with rounding away from zero
    acc_r1   = acc + (acc[ACC_W-1] ? ACC_W'(0) : ACC_W'(1));
    acc_half = acc_r1 >>> 1;
    // quintic: |v| + 12 ahead of the divide by 24
    acc_n    = acc[ACC_W-1] ? (ACC_W'(DIV_BIAS) - acc) : (acc + ACC_W'(DIV_BIAS));

    mul_p_ext = {{(PSUM_W-PROD_W){mul_p[PROD_W-1]}}, mul_p};
    ps_adj    = psum + (psum[PSUM_W-1] ? PSUM_W'(RND_30 - 1) : PSUM_W'(RND_30));
    ps_shr    = ps_adj >>> FRAC_W;
    ps_q      = psum >>> RECIP3_SH;
    q_t       = ps_q[KERN_W-1:0];

    last_dim  = dim == DIM_W'(DIMS - 1);
  end

  // shared multiplier operands
  always_comb begin
    mul_a = ma;
    mul_b = '0;
    unique case (state)
      S_HMUL: begin
        mul_a = {{(MA_W-ACC_W){acc[ACC_W-1]}}, acc};
        mul_b = {1'b0, mag};
      end
      S_PHI:   mul_b = mb[KERN_W-1:KERN_W-MB_W];
      S_PLO:   mul_b = {1'b0, mb[MB_W-2:0]};
      default: mul_b = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_OFF;
      S_OFF: begin
        if (zero_k || kernel_order == ORD_HAT) state_next = S_WGT;
        else state_next = S_HMUL;
      end
      S_HMUL: state_next = S_HADD;
      S_HADD: state_next = (step == 3'd0) ? S_KFIN : S_HMUL;
      S_KFIN: state_next = (kernel_order == ORD_CUBIC) ? S_WGT : S_PHI;
      S_WGT:  state_next = (dim == '0) ? S_NEXT : S_PHI;
      S_NEXT: state_next = last_dim ? S_PHI : S_OFF;
      S_PHI:  state_next = S_PLO;
      S_PLO:  state_next = S_PSUM;
      S_PSUM: state_next = S_PFIN;
      S_PFIN: begin
        unique case (kind)
          MK_WGT:  state_next = S_NEXT;
          MK_CON:  state_next = S_ACC;
          MK_DIV:  state_next = S_WGT;
          default: state_next = S_IDLE;
        endcase
      end
      S_ACC:   if (acc_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          for (int d = 0; d < DIMS; d++) begin
            pos[d]  <= in_data[d*POS_W +: POS_W];
            cidx[d] <= in_data[CELL_LSB + d*CELL_W +: CELL_W];
          end
          sample <= in_data[SMP_LSB +: SMP_W];
          last   <= in_last;
          dim    <= '0;
        end
      end
      S_OFF: begin
        mag <= mag_c;
        seg <= seg_c;
        if (zero_k) begin
          kern <= '0;
        end else if (kernel_order == ORD_HAT) begin
          kern <= hat_k;
        end else begin
          acc  <= start_c;
          step <= deg - 3'd1;
        end
      end
      S_HADD: begin
        acc <= acc_new;
        if (step != 3'd0) step <= step - 3'd1;
      end
      S_KFIN: begin
        if (kernel_order == ORD_CUBIC) begin
          kern <= acc_half[KERN_W-1:0];
        end else begin
          ma   <= $signed(RECIP3);
          mb   <= acc_n[KERN_W+DIV_SH-1:DIV_SH];
          kneg <= acc[ACC_W-1];
          kind <= MK_DIV;
        end
      end
      S_WGT: begin
        if (dim == '0) begin
          weight <= kern;
        end else begin
          ma   <= {{(MA_W-KERN_W){weight[KERN_W-1]}}, weight};
          mb   <= kern;
          kind <= MK_WGT;
        end
      end
      S_NEXT: begin
        if (last_dim) begin
          ma   <= {{(MA_W-SMP_W){sample[SMP_W-1]}}, sample};
          mb   <= weight;
          kind <= MK_CON;
        end else begin
          dim <= dim + DIM_W'(1);
        end
      end
      S_PLO:  psum <= mul_p_ext <<< (MB_W - 1);
      S_PSUM: psum <= psum + mul_p_ext;
      S_PFIN: begin
        unique case (kind)
          MK_WGT:  weight  <= ps_shr[KERN_W-1:0];
          MK_CON:  contrib <= ps_shr[CON_W-1:0];
          MK_DIV:  kern    <= kneg ? -q_t : q_t;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign in_ready        = state == S_IDLE;
  assign acc_req.valid   = state == S_ACC;
  assign acc_req.last    = last;
  assign acc_req.contrib = contrib;

endmodule

// ===== rtl/zspline_weighted_grid_sum.sv =====
// ----------------------------------------------------------------------------
// zspline_weighted_grid_sum : z-spline interpolation of a grid field
// Each input transaction is one stencil cell: query position, cell index
// and sample. The cell's sample is weighted by the product over the
// dimensions of a hat, cubic or quintic z-spline kernel of the offset
// between position and cell centre, and added to a saturating 56-bit sum.
// The cell flagged by tlast ends the stencil: the sum leaves on the master
// side, saturated to 48 bits, and the sum clears. One cell is in work at a
// time and all products go through one registered 48x17 multiplier;
// kernel polynomials are evaluated by horner steps, each a multiply state
// and an add state, and every 33-bit product (weight, division by 24,
// weighted sample) takes two passes. The next cell is accepted only once the
// previous one is done (tready is high only while idle); a dimension out of
// the kernel's reach skips its horner steps and, with the quintic, the
// division. A last cell also waits while the result register is full.
// kernel_order is written through the cfg port; the user must write it only
// while no cell is in work, the block itself does not enforce it.
// ----------------------------------------------------------------------------
module zspline_weighted_grid_sum import zsw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_data,       // kernel_order
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // pos_x, pos_y, pos_z, cell_x, cell_y, cell_z, sample, zero fill
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tlast,   // last_cell
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata    // interp_value
);

  order_t                   kernel_order;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;
  acc_req_t                 acc_req;
  logic                     acc_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_order <= ORD_CUBIC;
    end else if (cfg_valid && cfg_ready) begin
      kernel_order <= order_t'(cfg_data);
    end
  end

  zsw_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  zsw_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_data      (s_axis_tdata),
    .in_last      (s_axis_tlast),
    .kernel_order (kernel_order),
    .mul_a        (mul_a),
    .mul_b        (mul_b),
    .mul_p        (mul_p),
    .acc_req      (acc_req),
    .acc_ready    (acc_ready)
  );

  zsw_acc u_acc (
    .clk       (clk),
    .rst       (rst),
    .req       (acc_req),
    .req_ready (acc_ready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

`ifndef SYNTH
  // a cell in work blocks the next one
  a_one_cell: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("new cell accepted while one is in work");

  // a result appears only after the last cell's contribution was taken
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(acc_req.valid && acc_req.last && acc_ready))
    else $error("result without a last cell");

  // a stalled contribution waits unchanged
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    acc_req.valid && !acc_ready |=> acc_req.valid && $stable(acc_req.contrib))
    else $error("contribution changed while stalled");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for the z-spline weighted grid sum
// Drives stencils of grid cells on the slave stream, predicts every
// stencil's interpolated value with a bit-true fixed-point model of the
// hat, cubic and quintic kernels, and checks each master transaction
// against the oldest prediction. A short table of directed cells comes
// first, then random stencils over several kernel orders with random
// gaps on both streams and long receiver hold-offs.
// ----------------------------------------------------------------------------
module tb_top;
  import zsw_pkg::*;

  localparam int    HALF_PERIOD = 10;
  localparam int    RESET_CYCLES = 12;
  localparam int    DRAIN_CYCLES = 64;
  localparam int    CYCLE_LIMIT = 2000000;
  localparam int    RAND_PHASES = 8;
  localparam int    PHASE_CELLS = 231;
  localparam int    HOLD_CYCLES = 600;
  localparam int    MAX_REPORTS = 10;
  localparam longint QONE = 64'sd1 << 30;
  localparam longint CELL_LIM = (64'sd1 << INDEX_BITS) - 1;
  localparam longint SUM_HI = (64'sd1 << 55) - 1;
  localparam longint SUM_LO = -(64'sd1 << 55);
  localparam longint OUT_HI = (64'sd1 << 47) - 1;
  localparam longint OUT_LO = -(64'sd1 << 47);

  // segment polynomials, scaled by 2 and 24, lowest power first
  localparam longint CUBIC_TAB [2][4] = '{'{2, 0, -5, 3}, '{4, -8, 5, -1}};
  localparam longint QUINTIC_TAB [3][6] = '{
    '{24, 0, -30, -70, 126, -50},
    '{-96, 450, -735, 545, -189, 25},
    '{432, -918, 765, -313, 63, -5}
  };

  typedef struct {
    logic [POS_W-1:0]  px, py, pz;
    logic [CELL_W-1:0] cx, cy, cz;
    logic [SMP_W-1:0]  smp;
    logic              last;
  } stencil_cell_t;

  typedef struct {
    order_t           ord;
    stencil_cell_t    stim;
    bit               typed;
    logic [OUT_W-1:0] val;
  } directed_row_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_data = 2'd0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;

  // predictor state
  longint grid_sum = 0;
  order_t kern_order = ORD_CUBIC;

  logic [OUT_W-1:0] interp_due [$];
  directed_row_t    directed_rows [$];
  int               errs = 0;
  int               results_seen = 0;
  int               cycles = 0;
  bit               tx_calm = 1'b0;

  zspline_weighted_grid_sum dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // rnd(a*b / 2^30), ties away from zero, saturating magnitude
  function automatic longint round_mul_q30(longint a, longint b);
    logic         neg;
    logic [63:0]  ua, ub;
    logic [127:0] p;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    p = (p + (128'd1 << 29)) >> 30;
    if (p > 128'h7FFF_FFFF_FFFF_FFFF) p = 128'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint poly_eval(bit quin, int seg, longint t);
    longint acc;
    int     deg;
    deg = quin ? 5 : 3;
    acc = (quin ? QUINTIC_TAB[seg][deg] : CUBIC_TAB[seg][deg]) * QONE;
    for (int i = deg - 1; i >= 0; i--) begin
      acc = round_mul_q30(acc, t) + (quin ? QUINTIC_TAB[seg][i] : CUBIC_TAB[seg][i]) * QONE;
    end
    return acc;
  endfunction

  function automatic longint div_near(longint v, longint s);
    if (v >= 0) return (v + s / 2) / s;
    return -((-v + s / 2) / s);
  endfunction

  // kernel in Q2.30 for an absolute offset in Q.14
  function automatic longint zspline_kernel(order_t ord, longint mag);
    longint t;
    int     seg;
    if (mag >= (64'sd3 << 14)) return 0;
    t = mag << 16;
    seg = int'(mag >> 14);
    case (ord)
      ORD_HAT: return (seg == 0) ? QONE - t : 0;
      ORD_CUBIC: begin
        if (seg > 1) return 0;
        return div_near(poly_eval(1'b0, seg, t), 2);
      end
      ORD_QUINTIC: return div_near(poly_eval(1'b1, seg, t), 24);
      default: return 0;
    endcase
  endfunction

  function automatic void accumulate_cell(input stencil_cell_t c, output bit emit,
                                          output logic [OUT_W-1:0] val);
    longint            wgt, pos, cel, off, smp, contrib, res;
    logic [POS_W-1:0]  pa [3];
    logic [CELL_W-1:0] ca [3];
    pa = '{c.px, c.py, c.pz};
    ca = '{c.cx, c.cy, c.cz};
    wgt = QONE;
    for (int d = 0; d < DIMS && d < 3; d++) begin
      pos = pa[d];
      cel = ca[d];
      cel = cel & CELL_LIM;
      off = pos - ((cel << 14) + (64'sd1 << 13));
      if (off < 0) off = -off;
      wgt = round_mul_q30(wgt, zspline_kernel(kern_order, off));
    end
    smp = $signed(c.smp);
    contrib = round_mul_q30(smp, wgt);
    grid_sum = grid_sum + contrib;
    if (grid_sum > SUM_HI) grid_sum = SUM_HI;
    if (grid_sum < SUM_LO) grid_sum = SUM_LO;
    emit = c.last;
    val = '0;
    if (c.last) begin
      res = grid_sum;
      if (res > OUT_HI) res = OUT_HI;
      if (res < OUT_LO) res = OUT_LO;
      val = res[OUT_W-1:0];
      grid_sum = 0;
    end
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [POS_W-1:0] centre_of(int idx);
    return POS_W'(idx * (1 << POS_FRAC) + HALF_CELL);
  endfunction

  // position within a little over three cells of the cell centre
  function automatic logic [POS_W-1:0] near_pos(logic [CELL_W-1:0] idx);
    int p;
    p = int'(idx) * (1 << POS_FRAC) + HALF_CELL + int'($urandom_range(0, 104000)) - 52000;
    if (p < 0) p = 0;
    if (p > (1 << POS_W) - 1) p = (1 << POS_W) - 1;
    return POS_W'(p);
  endfunction

  function automatic logic [SMP_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h7FFF_FFFF;
    if (r == 1) return 32'h8000_0000;
    if (r == 2) return SMP_W'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    return $urandom;
  endfunction

  task automatic add_row(order_t o, logic [POS_W-1:0] px, py, pz, int cx, cy, cz,
                         logic [SMP_W-1:0] smp, bit last, bit typed,
                         logic [OUT_W-1:0] val);
    directed_row_t r;
    r.ord = o;
    r.stim = '{px, py, pz, CELL_W'(cx), CELL_W'(cy), CELL_W'(cz), smp, last};
    r.typed = typed;
    r.val = val;
    directed_rows = {directed_rows, r};
  endtask

  task automatic push_cell(stencil_cell_t c, bit typed, logic [OUT_W-1:0] typed_val);
    int               g;
    bit               emit;
    logic [OUT_W-1:0] v;
    g = pick_gap(tx_calm);
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_DATA_W'({c.smp, c.cz, c.cy, c.cx, c.pz, c.py, c.px});
    s_axis_tlast <= c.last;
    do @(posedge clk); while (!s_axis_tready);
    accumulate_cell(c, emit, v);
    if (emit) interp_due = {interp_due, (typed ? typed_val : v)};
  endtask

  // block is idle once the last stencil's result is out and it has settled
  task automatic settle_and_set_order(order_t o);
    s_axis_tvalid <= 1'b0;
    while (interp_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= o;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    kern_order = o;
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      if (interp_due.size() == 0) begin
        if (errs < MAX_REPORTS) begin
          $display("unexpected result %0d", $signed(m_axis_tdata));
        end
        errs++;
      end else begin
        if (m_axis_tdata !== interp_due[0]) begin
          if (errs < MAX_REPORTS) begin
            $display("interp_value mismatch: expected %0d, got %0d",
                     $signed(interp_due[0]), $signed(m_axis_tdata));
          end
          errs++;
        end
        void'(interp_due.pop_front());
      end
    end
  end

  // receiver: random gaps after each transaction, two long hold-offs
  int rx_wait = 0;
  int rx_hold = 0;
  int holds_done = 0;
  int next_hold_at = 20;
  bit rx_calm = 1'b0;

  always @(posedge clk) begin : rx_side
    int g;
    if (cycles % 256 == 0) rx_calm <= ($urandom_range(0, 3) == 0);
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (holds_done < 2 && results_seen >= next_hold_at) begin
      rx_hold <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
      next_hold_at <= next_hold_at + 40;
      m_axis_tready <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      g = pick_gap(rx_calm);
      rx_wait <= (g > 0) ? g - 1 : 0;
      m_axis_tready <= (g == 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rx_calm || ($urandom_range(0, 15) != 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[zspline_weighted_grid_sum] ERROR");
      $finish;
    end
  end

  initial begin
    stencil_cell_t c;
    order_t        phase_ord;
    int            sent, len, r;
    logic [OUT_W-1:0] none_val;
    none_val = '0;

    // cubic is the order after reset
    add_row(ORD_CUBIC, centre_of(5), centre_of(7), 24'd0, 5, 7, 0,
            32'h7FFF_FFFF, 1'b1, 1'b1, 48'sd2147483647);
    add_row(ORD_CUBIC, centre_of(0), centre_of(0), 24'hFF_FFFF, 0, 0, 1023,
            32'h8000_0000, 1'b1, 1'b1, 48'hFFFF_8000_0000);
    add_row(ORD_CUBIC, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1023, 1023, 1023,
            32'h0001_0000, 1'b1, 1'b0, none_val);
    // far offset gives nothing
    add_row(ORD_CUBIC, 24'd0, centre_of(3), 24'd0, 1023, 3, 0,
            32'h7FFF_FFFF, 1'b1, 1'b1, 48'd0);
    add_row(ORD_CUBIC, centre_of(2), centre_of(2), 24'd0, 2, 2, 0,
            32'h0003_0000, 1'b0, 1'b0, none_val);
    add_row(ORD_CUBIC, centre_of(2), centre_of(2), 24'd0, 2, 2, 0,
            32'hFFFF_0000, 1'b1, 1'b1, 48'd131072);
    add_row(ORD_CUBIC, POS_W'(centre_of(10) + 24576), POS_W'(centre_of(10) - 16384),
            24'd0, 10, 10, 0, 32'h0010_0000, 1'b0, 1'b0, none_val);
    add_row(ORD_CUBIC, POS_W'(centre_of(10) + 40960), POS_W'(centre_of(10) + 8191),
            24'd0, 10, 10, 0, 32'hFFF0_0000, 1'b0, 1'b0, none_val);
    add_row(ORD_CUBIC, POS_W'(centre_of(10) - 49151), centre_of(10), 24'd0, 10, 10, 0,
            32'h7FFF_FFFF, 1'b1, 1'b0, none_val);
    add_row(ORD_HAT, centre_of(100), centre_of(200), 24'hFF_FFFF, 100, 200, 1023,
            32'h1234_5678, 1'b1, 1'b1, 48'h1234_5678);
    add_row(ORD_HAT, POS_W'(centre_of(4) - 8192), POS_W'(centre_of(4) + 16383),
            24'd0, 4, 4, 0, 32'h7FFF_FFFF, 1'b0, 1'b0, none_val);
    add_row(ORD_HAT, POS_W'(centre_of(4) + 16384), centre_of(4), 24'd0, 4, 4, 0,
            32'h0000_0001, 1'b1, 1'b0, none_val);
    add_row(ORD_QUINTIC, centre_of(512), centre_of(511), 24'd0, 512, 511, 0,
            32'h7FFF_FFFF, 1'b1, 1'b1, 48'sd2147483647);
    add_row(ORD_QUINTIC, POS_W'(centre_of(20) + 20480), POS_W'(centre_of(20) - 45056),
            24'd0, 20, 20, 0, 32'h0001_0000, 1'b0, 1'b0, none_val);
    add_row(ORD_QUINTIC, POS_W'(centre_of(20) + 49151), POS_W'(centre_of(20) - 1),
            24'd0, 20, 20, 0, 32'h8000_0000, 1'b0, 1'b0, none_val);
    add_row(ORD_QUINTIC, POS_W'(centre_of(20) - 32768), POS_W'(centre_of(20) + 16384),
            24'd0, 20, 20, 0, 32'h7FFF_0000, 1'b1, 1'b0, none_val);
    // exactly three cells away is already outside the kernel
    add_row(ORD_QUINTIC, POS_W'(centre_of(20) + 49152), centre_of(20), 24'd0, 20, 20, 0,
            32'h7FFF_FFFF, 1'b1, 1'b1, 48'd0);
    // unused order weighs every cell with zero
    add_row(ORD_NONE, centre_of(6), centre_of(6), 24'hFF_FFFF, 6, 6, 1023,
            32'h7FFF_FFFF, 1'b1, 1'b1, 48'd0);
    add_row(ORD_NONE, POS_W'(centre_of(6) + 3), POS_W'(centre_of(6) - 7), 24'd0, 6, 6, 0,
            32'h8000_0000, 1'b1, 1'b1, 48'd0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].ord != kern_order) settle_and_set_order(directed_rows[i].ord);
      push_cell(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].val);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: phase_ord = ORD_QUINTIC;
        1: phase_ord = ORD_HAT;
        2: phase_ord = ORD_CUBIC;
        3: phase_ord = ORD_NONE;
        default: phase_ord = order_t'($urandom_range(0, 2));
      endcase
      settle_and_set_order(phase_ord);
      sent = 0;
      while (sent < PHASE_CELLS) begin
        r = $urandom_range(0, 99);
        if (r < 10) len = 1;
        else if (r < 80) len = $urandom_range(2, 16);
        else len = $urandom_range(17, 36);
        tx_calm = ($urandom_range(0, 4) == 0);
        for (int k = 0; k < len; k++) begin
          c.cx = CELL_W'($urandom);
          c.cy = CELL_W'($urandom);
          c.cz = CELL_W'($urandom);
          if ($urandom_range(0, 99) < 85) begin
            c.px = near_pos(c.cx);
            c.py = near_pos(c.cy);
            c.pz = near_pos(c.cz);
          end else begin
            c.px = POS_W'($urandom);
            c.py = POS_W'($urandom);
            c.pz = POS_W'($urandom);
          end
          c.smp = pick_sample();
          c.last = (k == len - 1);
          push_cell(c, 1'b0, none_val);
        end
        sent += len;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (interp_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errs == 0 && interp_due.size() == 0) begin
      $display("[zspline_weighted_grid_sum] OK");
    end else begin
      $display("[zspline_weighted_grid_sum] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/zsw_pkg.sv
rtl/zsw_mul.sv
rtl/zsw_acc.sv
rtl/zsw_seq.sv
rtl/zspline_weighted_grid_sum.sv
test/tb_top.sv
